FILE: rtl/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared types and constants of the biquad filter unit: default widths,
// register indexes and the command set from the controller to the datapath.
// ----------------------------------------------------------------------------
package bqf_pkg;

  // default field widths
  localparam int DEF_SAMPLE_BITS    = 16;
  localparam int DEF_COEF_FRAC_BITS = 14;

  // fraction bits kept in the history values
  localparam int HIST_FRAC = 8;

  // configuration register map
  localparam int NUM_COEF      = 5;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_A1 = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_A2 = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_B0 = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_B1 = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_COEF_B2 = 3'd4;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_A1_H1,
    MUL_A2_H2,
    MUL_B0_V,
    MUL_B1_H1,
    MUL_B2_H2
  } mul_sel_t;

  // accumulator operation
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_SUB,
    ACC_ADD,
    ACC_CLEAR
  } acc_op_t;

  // command bundle from controller to datapath
  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     v_load;
    logic     out_load;
    logic     clear;
  } bqf_cmd_t;

endpackage

FILE: rtl/bqf_datapath.sv
// ----------------------------------------------------------------------------
// bqf_datapath
// Coefficient registers, history, one shared multiplier with a product
// register, the accumulator, and the round/saturate logic for v and y.
// ----------------------------------------------------------------------------
module bqf_datapath
  import bqf_pkg::*;
#(
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [CFG_ADDR_BITS-1:0]          cfg_addr,
  input  logic [COEF_FRAC_BITS+3:0]         cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_in,
  input  bqf_cmd_t                          cmd,
  output logic signed [SAMPLE_BITS-1:0]     out_sample_out,
  output logic                              out_saturated
);

  localparam int COEF_BITS = COEF_FRAC_BITS + 4;
  localparam int HIST_BITS = SAMPLE_BITS + HIST_FRAC;
  localparam int PROD_BITS = COEF_BITS + HIST_BITS;
  localparam int ACC_BITS  = PROD_BITS + 2;
  localparam int X_SHIFT   = HIST_FRAC + COEF_FRAC_BITS;
  localparam int Y_SHIFT   = HIST_FRAC + COEF_FRAC_BITS;

  localparam logic signed [ACC_BITS-1:0] V_HALF =
    ACC_BITS'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_BITS-1:0] Y_HALF =
    ACC_BITS'(64'd1 << (Y_SHIFT - 1));
  localparam logic signed [COEF_BITS-1:0] B0_RESET =
    COEF_BITS'(64'd1 << COEF_FRAC_BITS);

  localparam logic signed [HIST_BITS-1:0] HIST_MAX = {1'b0, {(HIST_BITS-1){1'b1}}};
  localparam logic signed [HIST_BITS-1:0] HIST_MIN = {1'b1, {(HIST_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [COEF_BITS-1:0]   a1_r, a2_r, b0_r, b1_r, b2_r;
  logic signed [HIST_BITS-1:0]   h1_r, h2_r, v_r;
  logic                          sat_r;
  logic signed [PROD_BITS-1:0]   prod_r;
  logic signed [ACC_BITS-1:0]    acc_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_sat_r;

  logic signed [COEF_BITS-1:0]   op_c;
  logic signed [HIST_BITS-1:0]   op_h;
  logic signed [PROD_BITS-1:0]   mul_res;
  logic signed [ACC_BITS-1:0]    acc_nxt;
  logic signed [ACC_BITS-1:0]    v_sum, v_shift, y_sum, y_shift;
  logic                          v_ovf, y_ovf;
  logic signed [HIST_BITS-1:0]   v_clip;
  logic signed [SAMPLE_BITS-1:0] y_clip;

  // coefficient registers, writes beyond the map are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_r <= '0;
      a2_r <= '0;
      b0_r <= B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_COEF_A1: a1_r <= cfg_wdata;
        REG_COEF_A2: a2_r <= cfg_wdata;
        REG_COEF_B0: b0_r <= cfg_wdata;
        REG_COEF_B1: b1_r <= cfg_wdata;
        REG_COEF_B2: b2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_A1_H1: begin op_c = a1_r; op_h = h1_r; end
      MUL_A2_H2: begin op_c = a2_r; op_h = h2_r; end
      MUL_B0_V:  begin op_c = b0_r; op_h = v_r;  end
      MUL_B1_H1: begin op_c = b1_r; op_h = h1_r; end
      MUL_B2_H2: begin op_c = b2_r; op_h = h2_r; end
      default:   begin op_c = '0;   op_h = '0;   end
    endcase
  end

  assign mul_res = op_c * op_h;

  // product register
  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE) begin
      prod_r <= mul_res;
    end
  end

  // accumulator
  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD_X: acc_nxt = ACC_BITS'(in_sample_in) <<< X_SHIFT;
      ACC_SUB:    acc_nxt = acc_r - ACC_BITS'(prod_r);
      ACC_ADD:    acc_nxt = acc_r + ACC_BITS'(prod_r);
      ACC_CLEAR:  acc_nxt = '0;
      default:    acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // v: round half up to q.8 and clip to the history width
  assign v_sum   = acc_r + V_HALF;
  assign v_shift = v_sum >>> COEF_FRAC_BITS;
  assign v_ovf   = !((&v_shift[ACC_BITS-1:HIST_BITS-1]) ||
                     (~|v_shift[ACC_BITS-1:HIST_BITS-1]));
  assign v_clip  = v_ovf ? (v_shift[ACC_BITS-1] ? HIST_MIN : HIST_MAX)
                         : v_shift[HIST_BITS-1:0];

  // y: round half up to an integer and clip to the sample width
  assign y_sum   = acc_r + Y_HALF;
  assign y_shift = y_sum >>> Y_SHIFT;
  assign y_ovf   = !((&y_shift[ACC_BITS-1:SAMPLE_BITS-1]) ||
                     (~|y_shift[ACC_BITS-1:SAMPLE_BITS-1]));
  assign y_clip  = y_ovf ? (y_shift[ACC_BITS-1] ? SAMP_MIN : SAMP_MAX)
                         : y_shift[SAMPLE_BITS-1:0];

  // intermediate value and its clip flag
  always_ff @(posedge clk) begin
    if (cmd.v_load) begin
      v_r   <= v_clip;
      sat_r <= v_ovf;
    end
  end

  // history, cleared by reset and by the clear command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r <= '0;
      h2_r <= '0;
    end else if (cmd.out_load) begin
      if (cmd.clear) begin
        h1_r <= '0;
        h2_r <= '0;
      end else begin
        h1_r <= v_r;
        h2_r <= h1_r;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.clear) begin
        out_sample_r <= '0;
        out_sat_r    <= 1'b0;
      end else begin
        out_sample_r <= y_clip;
        out_sat_r    <= sat_r | y_ovf;
      end
    end
  end

  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

endmodule

FILE: rtl/bqf_ctrl.sv
// ----------------------------------------------------------------------------
// bqf_ctrl
// Sequencer of the filter: accepts a transaction, for a sample steps the
// shared multiplier through the five products, and loads the result register.
// ----------------------------------------------------------------------------
module bqf_ctrl
  import bqf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_func,
  output logic     out_valid,
  input  logic     out_ready,
  output bqf_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_FB1  = 11'b000_0000_0010,
    S_FB2  = 11'b000_0000_0100,
    S_FB3  = 11'b000_0000_1000,
    S_VOUT = 11'b000_0001_0000,
    S_FF1  = 11'b000_0010_0000,
    S_FF2  = 11'b000_0100_0000,
    S_FF3  = 11'b000_1000_0000,
    S_FF4  = 11'b001_0000_0000,
    S_DONE = 11'b010_0000_0000,
    S_CLR  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_accept;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // next state and command decode
  always_comb begin
    state_nxt    = state_r;
    cmd.mul_sel  = MUL_NONE;
    cmd.acc_op   = ACC_HOLD;
    cmd.v_load   = 1'b0;
    cmd.out_load = 1'b0;
    cmd.clear    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_func) begin
            state_nxt = S_CLR;
          end else begin
            cmd.acc_op = ACC_LOAD_X;
            state_nxt  = S_FB1;
          end
        end
      end
      S_FB1: begin
        cmd.mul_sel = MUL_A1_H1;
        state_nxt   = S_FB2;
      end
      S_FB2: begin
        cmd.mul_sel = MUL_A2_H2;
        cmd.acc_op  = ACC_SUB;
        state_nxt   = S_FB3;
      end
      S_FB3: begin
        cmd.acc_op = ACC_SUB;
        state_nxt  = S_VOUT;
      end
      S_VOUT: begin
        cmd.v_load = 1'b1;
        cmd.acc_op = ACC_CLEAR;
        state_nxt  = S_FF1;
      end
      S_FF1: begin
        cmd.mul_sel = MUL_B0_V;
        state_nxt   = S_FF2;
      end
      S_FF2: begin
        cmd.mul_sel = MUL_B1_H1;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = S_FF3;
      end
      S_FF3: begin
        cmd.mul_sel = MUL_B2_H2;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = S_FF4;
      end
      S_FF4: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CLR: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a clear transaction goes straight to the clear step
  a_clr_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_func) |=> (state_r == S_CLR))
    else $error("clear transaction did not enter clear step");

  // a sample transaction starts the feedback products
  a_fb_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_func) |=> (state_r == S_FB1))
    else $error("sample transaction did not start feedback");

  // a new result appears only from the done or clear step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r == S_DONE) || $past(state_r == S_CLR)))
    else $error("result flagged outside done or clear step");

  // a finished result waits while the previous one is not taken
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("result register overwritten before transaction taken");

endmodule

FILE: rtl/biquad_iir_filter_unit.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter_unit
// Direct form II biquad filter with five programmable Q3.14 coefficients.
// ----------------------------------------------------------------------------
// A transaction completes before the next one is accepted. One multiplier
// and its product register serve all five products: the feedback ones are
// subtracted from x, v is rounded and saturated, then the feed-forward ones
// are summed and y is rounded and saturated into the result register. The
// result register decouples the two channels, so a new transaction is
// accepted while a result still waits; a finished result waits in the done
// step only if the previous one has not been taken. The user must write
// coefficients through the cfg port only while idle; this is not enforced.
// ----------------------------------------------------------------------------
module biquad_iir_filter_unit
  import bqf_pkg::*;
#(
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_ADDR_BITS-1:0]      cfg_addr,
  input  logic [COEF_FRAC_BITS+3:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_saturated
);

  bqf_cmd_t cmd;

  // sequencer
  bqf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // arithmetic and storage
  bqf_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_sample_in   (in_sample_in),
    .cmd            (cmd),
    .out_sample_out (out_sample_out),
    .out_saturated  (out_saturated)
  );

endmodule
